@@ rtl/crm_pkg.sv @@
// ----------------------------------------------------------------------------
// crm_pkg: shared types and constants of the convolution reverb mixer
// Field widths, fixed-point shifts, register indexes, queue entry and
// configuration bundles used by the front, back and top level.
// ----------------------------------------------------------------------------
package crm_pkg;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int IDX_W    = 10;
   localparam int GAIN_W   = 16;
   localparam int MIX_W    = 13;
   localparam int CNT_W    = 11;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // datapath widths
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int ACC_W    = PROD_W + CNT_W;
   localparam int LO_W     = 22;
   localparam int HI_W     = ACC_W - LO_W;
   localparam int GM_A_W   = LO_W + 1;
   localparam int GM_B_W   = GAIN_W + 1;
   localparam int GM_P_W   = GM_A_W + GM_B_W;
   localparam int GP_W     = ACC_W + GAIN_W + 1;
   localparam int GAIN_SHIFT = 27;
   localparam int WET_W    = GP_W - GAIN_SHIFT;
   localparam int MIXW_W   = WET_W + MIX_W + 1;
   localparam int MIXD_W   = SAMPLE_W + MIX_W + 1;
   localparam int SUM_W    = MIXW_W + 1;
   localparam int MIX_SHIFT = 12;
   localparam int MIXS_W   = SUM_W - MIX_SHIFT;

   localparam logic signed [MIXS_W-1:0] SAT_HI = MIXS_W'(32767);
   localparam logic signed [MIXS_W-1:0] SAT_LO = -MIXS_W'(32768);

   // configuration limits and reset values
   localparam logic [GAIN_W-1:0] GAIN_MAX   = GAIN_W'(40960);
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);
   localparam logic [MIX_W-1:0]  MIX_MAX    = MIX_W'(4096);
   localparam logic [MIX_W-1:0]  DRY_RESET  = '0;
   localparam logic [MIX_W-1:0]  WET_RESET  = MIX_W'(4096);
   localparam logic [CNT_W-1:0]  TAPS_RESET = '0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WET_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DRY_MIX   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WET_MIX   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_COUNT = 2'd3;

   // request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_AUDIO = 1'b1;

   // request queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QP_W   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = QP_W + 1;
   localparam logic [QCNT_W-1:0] Q_FULL = QCNT_W'(QUEUE_DEPTH);

   typedef struct packed {
      logic                       kind;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic signed [SAMPLE_W-1:0] mono;
      logic [IDX_W-1:0]           tap_index;
      logic signed [SAMPLE_W-1:0] tap_value;
   } crm_entry_type;

   typedef struct packed {
      logic [GAIN_W-1:0] wet_gain;
      logic [MIX_W-1:0]  dry_mix;
      logic [MIX_W-1:0]  wet_mix;
      logic [CNT_W-1:0]  tap_count;
   } crm_cfg_type;

endpackage

@@ rtl/crm_ram.sv @@
// ----------------------------------------------------------------------------
// crm_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module crm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

@@ rtl/crm_front.sv @@
// ----------------------------------------------------------------------------
// crm_front: request intake and queue
// Accept requests, form the mono sample, drop loads beyond the tap store,
// and hold the rest in a short queue for the back end.
// ----------------------------------------------------------------------------
module crm_front #(
   parameter int MAX_TAPS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic signed [crm_pkg::SAMPLE_W-1:0]   req_left,
   input  logic signed [crm_pkg::SAMPLE_W-1:0]   req_right,
   input  logic [crm_pkg::IDX_W-1:0]             req_tap_index,
   input  logic signed [crm_pkg::SAMPLE_W-1:0]   req_tap_value,
   input  logic                                  pop,
   output logic                                  head_valid,
   output crm_pkg::crm_entry_type                head
);
   import crm_pkg::*;

   crm_entry_type             entries_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         count_ff, count_in;
   logic signed [SAMPLE_W:0]  pair_sum;
   logic                      in_range;
   logic                      push;
   crm_entry_type             entry;

   assign req_ready  = (count_ff != Q_FULL);
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

   always_comb begin
      pair_sum = (SAMPLE_W+1)'(req_left) + (SAMPLE_W+1)'(req_right);
      in_range = (32'(req_tap_index) < MAX_TAPS);
      // drop loads aimed past the end of the tap store
      push = req_valid && req_ready && ((req_kind == KIND_AUDIO) || in_range);

      entry.kind      = req_kind;
      entry.left      = req_left;
      entry.right     = req_right;
      entry.mono      = pair_sum[SAMPLE_W:1];
      entry.tap_index = req_tap_index;
      entry.tap_value = req_tap_value;

      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry;
      end
   end

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_FULL)
      else $error("queue count beyond depth");

endmodule

@@ rtl/crm_back.sv @@
// ----------------------------------------------------------------------------
// crm_back: convolution and mix engine
// Pop queued requests, write taps and history, run the multiply-accumulate
// over the history, scale, mix, saturate and present the result.
// ----------------------------------------------------------------------------
module crm_back #(
   parameter int MAX_TAPS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  crm_pkg::crm_cfg_type                  cfg,
   input  logic                                  head_valid,
   input  crm_pkg::crm_entry_type                head,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [crm_pkg::SAMPLE_W-1:0]   rsp_left,
   output logic signed [crm_pkg::SAMPLE_W-1:0]   rsp_right,
   output logic                                  rsp_clipped
);
   import crm_pkg::*;

   localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int NW = $clog2(MAX_TAPS + 1);
   localparam logic [AW-1:0] LAST_POS = AW'(MAX_TAPS - 1);
   localparam logic [NW-1:0] FILL_MAX = NW'(MAX_TAPS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MAC  = 3'd1;
   localparam logic [2:0] S_GLO  = 3'd2;
   localparam logic [2:0] S_GHI  = 3'd3;
   localparam logic [2:0] S_WET  = 3'd4;
   localparam logic [2:0] S_MIXW = 3'd5;
   localparam logic [2:0] S_MIXD = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   // control
   logic [2:0]     state_ff, state_in;
   logic [AW-1:0]  hist_ptr_ff, hist_ptr_in;
   logic [NW-1:0]  fill_ff, fill_in;
   logic [NW-1:0]  k_ff, k_in;
   logic [NW-1:0]  n_ff, n_in;
   logic           rd_v_ff, rd_v_in;
   logic           prod_v_ff, prod_v_in;
   logic           out_valid_ff, out_valid_in;

   // payload
   logic [AW-1:0]                rdpos_ff, rdpos_in;
   logic                         pass_ff, pass_in;
   logic signed [SAMPLE_W-1:0]   mono_ff, mono_in;
   logic signed [SAMPLE_W-1:0]   left_ff, left_in;
   logic signed [SAMPLE_W-1:0]   right_ff, right_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [GM_P_W-1:0]     plo_ff, plo_in;
   logic signed [GM_P_W-1:0]     phi_ff, phi_in;
   logic signed [WET_W-1:0]      wet_ff, wet_in;
   logic signed [MIXW_W-1:0]     mixw_ff, mixw_in;
   logic signed [MIXD_W-1:0]     mixd_ff, mixd_in;
   logic signed [SAMPLE_W-1:0]   out_left_ff, out_left_in;
   logic signed [SAMPLE_W-1:0]   out_right_ff, out_right_in;
   logic                         out_clip_ff, out_clip_in;

   // datapath
   logic [NW-1:0]                fill_nx;
   logic signed [GM_A_W-1:0]     gm_a;
   logic signed [GM_B_W-1:0]     gm_b;
   logic signed [GM_P_W-1:0]     gm_p;
   logic signed [GP_W-1:0]       wsum;
   logic signed [SUM_W-1:0]      msum;
   logic signed [MIXS_W-1:0]     mixs;
   logic signed [SAMPLE_W-1:0]   sat_val;
   logic                         sat_clip;
   logic                         issue;
   logic                         out_load;

   // memories
   logic                 tap_we;
   logic [AW-1:0]        tap_waddr;
   logic [SAMPLE_W-1:0]  tap_rdata;
   logic                 hist_we;
   logic [SAMPLE_W-1:0]  hist_rdata;

   crm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_tap_ram (
      .clock   (clock),
      .wr_en   (tap_we),
      .wr_addr (tap_waddr),
      .wr_data (head.tap_value),
      .rd_en   (issue),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (tap_rdata)
   );

   crm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_ptr_ff),
      .wr_data (head.mono),
      .rd_en   (issue),
      .rd_addr (rdpos_ff),
      .rd_data (hist_rdata)
   );

   assign tap_waddr = AW'(head.tap_index);

   // one shared multiplier splits acc * gain into low and high halves
   assign gm_a = (state_ff == S_GHI) ? GM_A_W'($signed(acc_ff[ACC_W-1:LO_W]))
                                     : GM_A_W'({1'b0, acc_ff[LO_W-1:0]});
   assign gm_b = GM_B_W'({1'b0, cfg.wet_gain});
   assign gm_p = gm_a * gm_b;

   assign wsum = (GP_W'(phi_ff) <<< LO_W) + GP_W'(plo_ff);
   assign msum = SUM_W'(mixw_ff) + SUM_W'(mixd_ff);
   assign mixs = msum[SUM_W-1:MIX_SHIFT];

   always_comb begin
      priority if (mixs > SAT_HI) begin
         sat_val  = SAMPLE_W'(SAT_HI);
         sat_clip = 1'b1;
      end else if (mixs < SAT_LO) begin
         sat_val  = SAMPLE_W'(SAT_LO);
         sat_clip = 1'b1;
      end else begin
         sat_val  = mixs[SAMPLE_W-1:0];
         sat_clip = 1'b0;
      end
   end

   assign fill_nx = (fill_ff == FILL_MAX) ? fill_ff : fill_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      hist_ptr_in  = hist_ptr_ff;
      fill_in      = fill_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      rdpos_in     = rdpos_ff;
      pass_in      = pass_ff;
      mono_in      = mono_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      acc_in       = acc_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      wet_in       = wet_ff;
      mixw_in      = mixw_ff;
      mixd_in      = mixd_ff;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      out_clip_in  = out_clip_ff;
      pop          = 1'b0;
      tap_we       = 1'b0;
      hist_we      = 1'b0;
      issue        = 1'b0;
      out_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               if (head.kind == KIND_LOAD) begin
                  tap_we = 1'b1;
               end else begin
                  hist_we     = 1'b1;
                  hist_ptr_in = (hist_ptr_ff == LAST_POS) ? '0 : hist_ptr_ff + 1'b1;
                  fill_in     = fill_nx;
                  rdpos_in    = hist_ptr_ff;
                  mono_in     = head.mono;
                  left_in     = head.left;
                  right_in    = head.right;
                  pass_in     = (cfg.tap_count == '0);
                  k_in        = '0;
                  acc_in      = '0;
                  // history beyond the samples seen since reset reads as zero
                  if (32'(cfg.tap_count) < 32'(fill_nx)) begin
                     n_in = NW'(cfg.tap_count);
                  end else begin
                     n_in = fill_nx;
                  end
                  state_in = (cfg.tap_count == '0) ? S_OUT : S_MAC;
               end
            end
         end
         S_MAC: begin
            if (k_ff != n_ff) begin
               issue    = 1'b1;
               k_in     = k_ff + 1'b1;
               rdpos_in = (rdpos_ff == '0) ? LAST_POS : rdpos_ff - 1'b1;
            end else if (!rd_v_ff && !prod_v_ff) begin
               state_in = S_GLO;
            end
            if (prod_v_ff) begin
               acc_in = acc_ff + ACC_W'(prod_ff);
            end
         end
         S_GLO: begin
            plo_in   = gm_p;
            state_in = S_GHI;
         end
         S_GHI: begin
            phi_in   = gm_p;
            state_in = S_WET;
         end
         S_WET: begin
            wet_in   = wsum[GP_W-1:GAIN_SHIFT];
            state_in = S_MIXW;
         end
         S_MIXW: begin
            mixw_in  = wet_ff * MIXW_W'($signed({1'b0, cfg.wet_mix}));
            state_in = S_MIXD;
         end
         S_MIXD: begin
            mixd_in  = mono_ff * MIXD_W'($signed({1'b0, cfg.dry_mix}));
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_load     = 1'b1;
               out_left_in  = pass_ff ? left_ff : sat_val;
               out_right_in = pass_ff ? right_ff : sat_val;
               out_clip_in  = pass_ff ? 1'b0 : sat_clip;
               state_in     = S_IDLE;
            end
         end
      endcase

      rd_v_in      = issue;
      prod_v_in    = rd_v_ff;
      prod_in      = $signed(tap_rdata) * $signed(hist_rdata);
      out_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hist_ptr_ff  <= '0;
         fill_ff      <= '0;
         k_ff         <= '0;
         n_ff         <= '0;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hist_ptr_ff  <= hist_ptr_in;
         fill_ff      <= fill_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         rd_v_ff      <= rd_v_in;
         prod_v_ff    <= prod_v_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rdpos_ff     <= rdpos_in;
      pass_ff      <= pass_in;
      mono_ff      <= mono_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      wet_ff       <= wet_in;
      mixw_ff      <= mixw_in;
      mixd_ff      <= mixd_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      out_clip_ff  <= out_clip_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_left    = out_left_ff;
   assign rsp_right   = out_right_ff;
   assign rsp_clipped = out_clip_ff;

   a_drain_before_scale: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC && state_in == S_GLO) |-> (!rd_v_ff && !prod_v_ff))
      else $error("scaling began with products still in flight");

   a_taps_bounded: assert property (@(posedge clock) disable iff (reset)
      (k_ff <= n_ff) && (fill_ff <= FILL_MAX))
      else $error("tap counter or history fill out of range");

   a_pass_keeps_input: assert property (@(posedge clock) disable iff (reset)
      (out_load && pass_ff) |=> (!rsp_clipped && rsp_left == $past(left_ff)))
      else $error("passthrough result altered");

endmodule

@@ rtl/convolution_reverb_mix.sv @@
// ----------------------------------------------------------------------------
// convolution_reverb_mix: FIR convolution reverb with dry/wet mix
// Loads impulse coefficients, convolves a mono history against them, scales,
// mixes with the dry sample and saturates to a stereo result.
// ----------------------------------------------------------------------------
// A load request (tuser 0) writes one coefficient and returns nothing; loads
// addressed past MAX_TAPS are dropped. An audio request (tuser 1) returns one
// result carrying the same mixed value on both channels, or the untouched
// stereo input when tap_count is zero. Requests pass through a four-entry
// queue into a single multiply-accumulate engine fed by the tap and history
// RAM read ports, one tap per cycle; an audio request runs n taps, where n
// is the smaller of tap_count and the number of audio requests seen since
// reset. The engine works on one request at a time and takes the next only
// once its result has gone into the result register, which waits for the
// previous result to be taken. History not yet written since reset reads as
// zero by limiting the tap run to the fill count, so no clearing pass follows
// reset. Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module convolution_reverb_mix #(
   parameter int MAX_TAPS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: left_in[15:0], right_in[31:16], tap_index[41:32], tap_value[57:42]
   input  logic [63:0]                        req_tdata,
   // tuser: kind[0]
   input  logic                               req_tuser,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: left_out[15:0], right_out[31:16]
   output logic [31:0]                        rsp_tdata,
   // tuser: clipped[0]
   output logic                               rsp_tuser,
   // configuration writes
   input  logic                               csr_we,
   input  logic [crm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [crm_pkg::CSR_W-1:0]          csr_wdata
);
   import crm_pkg::*;

   // tap_count never exceeds the tap store
   localparam logic [CNT_W-1:0] TAPS_CAP =
      (MAX_TAPS > 2047) ? CNT_W'(2047) : CNT_W'(MAX_TAPS);

   crm_cfg_type               cfg_ff, cfg_in;
   logic                      head_valid;
   crm_entry_type             head;
   logic                      pop;
   logic signed [SAMPLE_W-1:0] rsp_left, rsp_right;

   // Configuration registers: clamp each write to its legal range; all four
   // indexes name a register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_WET_GAIN: begin
               cfg_in.wet_gain = (csr_wdata > GAIN_MAX) ? GAIN_MAX : csr_wdata;
            end
            REG_DRY_MIX: begin
               cfg_in.dry_mix = (csr_wdata[MIX_W-1:0] > MIX_MAX) ? MIX_MAX
                                                                 : csr_wdata[MIX_W-1:0];
            end
            REG_WET_MIX: begin
               cfg_in.wet_mix = (csr_wdata[MIX_W-1:0] > MIX_MAX) ? MIX_MAX
                                                                 : csr_wdata[MIX_W-1:0];
            end
            REG_TAP_COUNT: begin
               cfg_in.tap_count = (csr_wdata[CNT_W-1:0] > TAPS_CAP) ? TAPS_CAP
                                                                    : csr_wdata[CNT_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wet_gain  <= GAIN_RESET;
         cfg_ff.dry_mix   <= DRY_RESET;
         cfg_ff.wet_mix   <= WET_RESET;
         cfg_ff.tap_count <= TAPS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: take requests, form mono, queue them.
   crm_front #(.MAX_TAPS(MAX_TAPS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_kind      (req_tuser),
      .req_left      (req_tdata[15:0]),
      .req_right     (req_tdata[31:16]),
      .req_tap_index (req_tdata[41:32]),
      .req_tap_value (req_tdata[57:42]),
      .pop           (pop),
      .head_valid    (head_valid),
      .head          (head)
   );

   // Back end: convolve, scale, mix, saturate and hold the result.
   crm_back #(.MAX_TAPS(MAX_TAPS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_left    (rsp_left),
      .rsp_right   (rsp_right),
      .rsp_clipped (rsp_tuser)
   );

   assign rsp_tdata = {rsp_right, rsp_left};

endmodule

@@ dv/convolution_reverb_mix_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// convolution_reverb_mix_checker: request/result scoreboard for the mixer
// Watches the request, result and register ports, keeps its own copy of the
// coefficients, history and settings, predicts each mixed sample and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module convolution_reverb_mix_checker #(
   parameter int MAX_TAPS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   // tdata: left_in[15:0], right_in[31:16], tap_index[41:32], tap_value[57:42]
   input  logic [63:0]                   req_tdata,
   // tuser: kind[0]
   input  logic                          req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // tdata: left_out[15:0], right_out[31:16]
   input  logic [31:0]                   rsp_tdata,
   // tuser: clipped[0]
   input  logic                          rsp_tuser,
   input  logic                          csr_we,
   input  logic [crm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [crm_pkg::CSR_W-1:0]     csr_wdata,
   output int                            failures,
   output int                            outstanding
);
   import crm_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       clipped;
   } mix_result_type;

   logic [GAIN_W-1:0]          gain_q412;
   logic [MIX_W-1:0]           dry_weight;
   logic [MIX_W-1:0]           wet_weight;
   logic [CNT_W-1:0]           taps_active;
   logic signed [SAMPLE_W-1:0] coeff_mem [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] mono_history [MAX_TAPS];
   int                         history_wr;
   mix_result_type             expected_mix_q [$];

   function automatic mix_result_type compute_reverb_sample(
      input logic signed [SAMPLE_W-1:0] left,
      input logic signed [SAMPLE_W-1:0] right
   );
      mix_result_type           res;
      logic signed [SAMPLE_W:0] pair_sum;
      logic signed [SAMPLE_W-1:0] mono;
      longint                   acc;
      longint                   wet;
      longint                   mix;
      int                       newest;
      pair_sum = left + right;
      mono = SAMPLE_W'(pair_sum >>> 1);
      newest = history_wr;
      mono_history[newest] = mono;
      history_wr = (history_wr + 1) % MAX_TAPS;
      if (taps_active == 0) begin
         res.left = left;
         res.right = right;
         res.clipped = 1'b0;
         return res;
      end
      // tap 0 meets the newest sample, tap k the one k requests older
      acc = 0;
      for (int k = 0; k < taps_active; k++) begin
         acc += longint'(coeff_mem[k])
              * longint'(mono_history[(newest + MAX_TAPS - k) % MAX_TAPS]);
      end
      wet = (acc * longint'(gain_q412)) >>> GAIN_SHIFT;
      mix = (longint'(mono) * longint'(dry_weight) + wet * longint'(wet_weight))
            >>> MIX_SHIFT;
      res.clipped = (mix > 32767) || (mix < -32768);
      if (mix > 32767)
         res.left = 16'sh7FFF;
      else if (mix < -32768)
         res.left = 16'sh8000;
      else
         res.left = SAMPLE_W'(mix);
      res.right = res.left;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      mix_result_type got;
      mix_result_type want;
      if (reset) begin
         gain_q412 = GAIN_RESET;
         dry_weight = DRY_RESET;
         wet_weight = WET_RESET;
         taps_active = TAPS_RESET;
         for (int i = 0; i < MAX_TAPS; i++)
            mono_history[i] = '0;
         history_wr = 0;
         expected_mix_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_WET_GAIN: begin
                  gain_q412 = (csr_wdata > GAIN_MAX) ? GAIN_MAX : csr_wdata;
               end
               REG_DRY_MIX: begin
                  dry_weight = (csr_wdata[MIX_W-1:0] > MIX_MAX) ? MIX_MAX
                                                                : csr_wdata[MIX_W-1:0];
               end
               REG_WET_MIX: begin
                  wet_weight = (csr_wdata[MIX_W-1:0] > MIX_MAX) ? MIX_MAX
                                                                : csr_wdata[MIX_W-1:0];
               end
               REG_TAP_COUNT: begin
                  taps_active = (csr_wdata[CNT_W-1:0] > MAX_TAPS) ? CNT_W'(MAX_TAPS)
                                                                  : csr_wdata[CNT_W-1:0];
               end
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.left = rsp_tdata[15:0];
            got.right = rsp_tdata[31:16];
            got.clipped = rsp_tuser;
            if (expected_mix_q.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: result with nothing pending: left %0d right %0d clip %0b",
                           $time, got.left, got.right, got.clipped);
            end else begin
               want = expected_mix_q.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= 10)
                     $display("%0t: mismatch: exp l %0d r %0d c %0b, got l %0d r %0d c %0b",
                              $time, want.left, want.right, want.clipped,
                              got.left, got.right, got.clipped);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == KIND_LOAD) begin
               if (req_tdata[41:32] < MAX_TAPS)
                  coeff_mem[req_tdata[41:32]] = req_tdata[57:42];
            end else begin
               expected_mix_q.push_back(compute_reverb_sample(req_tdata[15:0],
                                                              req_tdata[31:16]));
            end
         end
      end
      outstanding = expected_mix_q.size();
   end

endmodule

@@ dv/convolution_reverb_mix_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// convolution_reverb_mix_tb: stimulus and verdict for the reverb mixer
// Drives passthrough and register-limit cases, loads the leading coefficients,
// then runs randomised setting phases and a long audio run with a
// stalled receiver; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module convolution_reverb_mix_tb;
   import crm_pkg::*;

   localparam int MAX_TAPS     = 1024;
   // coefficients written up front; no tap run reaches past them
   localparam int LOADED_TAPS  = 256;
   // an audio request at full length keeps the engine busy through MAX_TAPS taps;
   // allow many times that before calling the run hung
   localparam int STALL_LIMIT  = 20000;
   // loads return nothing, so give queued ones time to retire before writes
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASES       = 12;
   localparam int RUN_ITEMS    = 180;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [63:0]          req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [31:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int                   failures;
   int                   outstanding;
   int                   quiet_cycles;

   // idling switches, flipped per phase so some stretches run flat out
   bit req_idle_on  = 1'b1;
   bit rsp_idle_on  = 1'b1;
   bit rsp_hold_req = 1'b0;

   convolution_reverb_mix #(.MAX_TAPS(MAX_TAPS)) uut (.*);

   convolution_reverb_mix_checker #(.MAX_TAPS(MAX_TAPS)) mix_check (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly back-to-back, sometimes a short pause, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return 0;
      if (roll < 94)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Full-scale corners turn up often enough to hit both clip directions.
   function automatic logic [15:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Present one request and hold it until the block takes it. The next
   // request, if any, follows at the next falling edge unless an idle gap is picked.
   task automatic offer_request(input logic kind, input logic [63:0] data);
      int gap;
      gap = req_idle_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   // Unused fields carry noise: the block must ignore them.
   task automatic send_audio(input logic [15:0] left, input logic [15:0] right);
      offer_request(KIND_AUDIO, {6'b0, 16'($urandom), 10'($urandom), right, left});
   endtask

   task automatic send_load(input logic [9:0] index, input logic [15:0] value);
      offer_request(KIND_LOAD, {6'b0, value, index, 16'($urandom), 16'($urandom)});
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Drop valid, wait for every pending result, then let trailing loads retire.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Result side: random stalls, plus one long hold on request from stimulus.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_idle_on)
               hold_left = pick_gap();
         end
      end
   end

   // Watchdog: any handshake on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int taps;
      int phase_items;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_LOAD;
      csr_we = 1'b0;
      csr_index = REG_WET_GAIN;
      csr_wdata = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Passthrough at reset settings: stereo must come back untouched.
      send_audio(16'h7FFF, 16'h8000);
      send_audio(16'h8000, 16'h8000);
      send_audio(16'h7FFF, 16'h7FFF);
      send_audio(16'h0000, 16'h0000);

      // Write the leading coefficients once so no later tap run reads a blank
      // entry, then pin the first taps and the last loaded one to full scale.
      for (int i = 0; i < LOADED_TAPS; i++)
         send_load(10'(i), 16'($urandom));
      send_load(10'd0, 16'h7FFF);
      send_load(10'd1, 16'h8000);
      send_load(10'(LOADED_TAPS - 1), 16'h8000);
      settle();

      // Over-range writes: gain and dry weight must clamp to their maxima.
      write_reg(REG_WET_GAIN, 16'hFFFF);
      write_reg(REG_DRY_MIX, 16'hFFFF);
      write_reg(REG_WET_MIX, 16'd4096);
      write_reg(REG_TAP_COUNT, 16'd2);
      send_audio(16'h7FFF, 16'h7FFF);
      send_audio(16'h8000, 16'h8000);
      send_audio(16'hFFFF, 16'h0000);
      settle();

      // Every loaded tap with no wet gain: the dry path alone must give back
      // the mono sample.
      write_reg(REG_WET_GAIN, 16'd0);
      write_reg(REG_TAP_COUNT, 16'(LOADED_TAPS));
      send_audio(random_sample(), random_sample());
      send_audio(16'h8000, 16'h7FFF);
      settle();

      // Every loaded tap at maximum gain, wet only.
      write_reg(REG_WET_GAIN, 16'd40960);
      write_reg(REG_DRY_MIX, 16'd0);
      send_audio(16'h7FFF, 16'h7FFF);
      send_audio(random_sample(), random_sample());
      settle();

      // Both weights at zero: silence whatever comes in.
      write_reg(REG_WET_MIX, 16'd0);
      send_audio(16'h7FFF, 16'h7FFF);
      settle();

      // Random phases: fresh settings each time, mostly short filters.
      for (int p = 0; p < PHASES; p++) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 3))
            0:       write_reg(REG_WET_GAIN, 16'($urandom_range(0, 40960)));
            1:       write_reg(REG_WET_GAIN, 16'($urandom_range(0, 8192)));
            2:       write_reg(REG_WET_GAIN, 16'($urandom));
            default: write_reg(REG_WET_GAIN, 16'd40960);
         endcase
         write_reg(REG_DRY_MIX, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 4096)));
         write_reg(REG_WET_MIX, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 4096)));
         case ($urandom_range(0, 7))
            0:       taps = 0;
            1:       taps = $urandom_range(25, LOADED_TAPS);
            2:       taps = LOADED_TAPS;
            default: taps = $urandom_range(1, 24);
         endcase
         write_reg(REG_TAP_COUNT, 16'(taps));
         // keep long-filter phases short, each request runs through every active tap
         phase_items = (taps > 100) ? 6 : 12;
         for (int n = 0; n < phase_items; n++) begin
            if ($urandom_range(0, 4) == 0)
               send_load(10'($urandom), 16'($urandom));
            else
               send_audio(random_sample(), random_sample());
         end
         settle();
      end

      // Long audio run with a short filter. Open with a long receiver hold
      // while requests keep coming, so the queue fills and the block must
      // stall its input.
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      write_reg(REG_WET_GAIN, 16'd4096);
      write_reg(REG_DRY_MIX, 16'd2048);
      write_reg(REG_WET_MIX, 16'd2048);
      write_reg(REG_TAP_COUNT, 16'd8);
      rsp_hold_req = 1'b1;
      for (int n = 0; n < RUN_ITEMS; n++) begin
         if (n == RUN_ITEMS / 2)
            req_idle_on = 1'b1;
         send_audio(random_sample(), random_sample());
      end
      settle();

      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/crm_pkg.sv
rtl/crm_ram.sv
rtl/crm_front.sv
rtl/crm_back.sv
rtl/convolution_reverb_mix.sv
dv/convolution_reverb_mix_checker.sv
dv/convolution_reverb_mix_tb.sv
